// File: rtl/tsdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text screen damage tracker package
// Shared types and constants: sequencer states, request and choice codes,
// cell encoding and cost constants.
// ----------------------------------------------------------------------------
package tsdt_pkg;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_COMMIT,
        ST_FLUSH,
        ST_DONE
    } state_t;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_COMMIT = 2'd2;

    localparam logic [1:0] CHOICE_NONE    = 2'd0;
    localparam logic [1:0] CHOICE_CHANGES = 2'd1;
    localparam logic [1:0] CHOICE_REDRAW  = 2'd2;

    localparam int CELL_W = 9;
    localparam logic [CELL_W-1:0] SPACE_CELL = 9'h020;

    localparam int COST_PER_CELL = 9;
    localparam int ROW_OVERHEAD  = 8;

    localparam int CHANGED_W = 9;
    localparam int BYTES_W   = 13;

endpackage
`default_nettype wire

// File: rtl/text_screen_damage_tracker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text screen damage tracker
// Draw and shown character-cell buffers with a commit that counts changed
// cells and picks the cheaper kind of screen update.
// ----------------------------------------------------------------------------
// After reset the block fills both buffers with spaces and accepts no
// transfer during that pass. Cell writes can follow each other in every
// cycle while the sequencer is idle. A clear and a commit are each run by the
// single sequencer, which steps one address per cycle: a clear writes spaces
// into the draw memory, and a commit walks both cell memories through one
// compare unit. A commit holds in its last state while an earlier result
// still waits on the master side. Only a commit gives a result.
module text_screen_damage_tracker_top #(
    parameter int COLUMNS = 40,
    parameter int ROWS    = 12
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // col_x[7:0], row_y[15:8], cell_char[23:16], cell_attr[24], zero fill
    input  wire logic [31:0] s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // changed_cells[8:0], diff_bytes[21:9], zero fill
    output logic [23:0]      m_tdata,
    // update_choice[1:0]
    output logic [1:0]       m_tuser
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int PART_W     = CNT_W + 4;
    localparam int FULL_W     = PART_W + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
    localparam logic [FULL_W-1:0] FULL_COST =
        FULL_W'(CELL_COUNT + ROWS * tsdt_pkg::ROW_OVERHEAD);

    localparam int CW = tsdt_pkg::CELL_W;

    tsdt_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [ADDR_W-1:0] cmp_addr_reg, cmp_addr_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [tsdt_pkg::CHANGED_W-1:0] out_cells_reg, out_cells_next;
    logic [tsdt_pkg::BYTES_W-1:0]   out_bytes_reg, out_bytes_next;
    logic [1:0]        out_choice_reg, out_choice_next;

    logic [CW-1:0] draw_mem  [CELL_COUNT];
    logic [CW-1:0] shown_mem [CELL_COUNT];
    logic [CW-1:0] draw_rd_reg;
    logic [CW-1:0] shown_rd_reg;

    logic              draw_we;
    logic [ADDR_W-1:0] draw_waddr;
    logic [CW-1:0]     draw_wdata;
    logic              shown_we;
    logic [ADDR_W-1:0] shown_waddr;
    logic [CW-1:0]     shown_wdata;

    logic [7:0]        col_x;
    logic [7:0]        row_y;
    logic [7:0]        cell_char;
    logic              cell_attr;
    logic              on_screen;
    logic [14:0]       write_addr;
    logic [PART_W-1:0] part_cost;
    logic [31:0]       count_wide;
    logic [31:0]       part_wide;
    logic [1:0]        choice;

    assign col_x     = s_tdata[7:0];
    assign row_y     = s_tdata[15:8];
    assign cell_char = s_tdata[23:16];
    assign cell_attr = s_tdata[24];

    assign on_screen = !col_x[7] && !row_y[7]
                       && (32'(col_x) < 32'(COLUMNS))
                       && (32'(row_y) < 32'(ROWS));
    assign write_addr = 15'(15'(row_y[6:0]) * 15'(COLUMNS)) + 15'(col_x[6:0]);

    assign part_cost  = PART_W'(count_reg) * PART_W'(tsdt_pkg::COST_PER_CELL);
    assign count_wide = 32'(count_reg);
    assign part_wide  = 32'(part_cost);

    always_comb
    begin
        priority if (count_reg == '0)
        begin
            choice = tsdt_pkg::CHOICE_NONE;
        end
        else if ({1'b0, part_cost} < FULL_COST)
        begin
            choice = tsdt_pkg::CHOICE_CHANGES;
        end
        else
        begin
            choice = tsdt_pkg::CHOICE_REDRAW;
        end
    end

    always_ff @(posedge clk)
    begin
        if (draw_we)
        begin
            draw_mem[draw_waddr] <= draw_wdata;
        end
        draw_rd_reg <= draw_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (shown_we)
        begin
            shown_mem[shown_waddr] <= shown_wdata;
        end
        shown_rd_reg <= shown_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsdt_pkg::ST_INIT;
            idx_reg       <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_addr_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_addr_reg  <= cmp_addr_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_cells_reg  <= out_cells_next;
        out_bytes_reg  <= out_bytes_next;
        out_choice_reg <= out_choice_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        cmp_valid_next  = 1'b0;
        cmp_addr_next   = idx_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_cells_next  = out_cells_reg;
        out_bytes_next  = out_bytes_reg;
        out_choice_next = out_choice_reg;
        s_tready        = 1'b0;
        draw_we         = 1'b0;
        draw_waddr      = idx_reg;
        draw_wdata      = tsdt_pkg::SPACE_CELL;
        shown_we        = 1'b0;
        shown_waddr     = idx_reg;
        shown_wdata     = tsdt_pkg::SPACE_CELL;

        // The compare stage retires one cell per cycle behind the read.
        if (cmp_valid_reg)
        begin
            shown_we    = 1'b1;
            shown_waddr = cmp_addr_reg;
            shown_wdata = draw_rd_reg;
            if (draw_rd_reg != shown_rd_reg)
            begin
                count_next = count_reg + 1'b1;
            end
        end

        unique case (state_reg)
            tsdt_pkg::ST_INIT:
            begin
                draw_we  = 1'b1;
                shown_we = 1'b1;
                if (idx_reg == LAST_ADDR)
                begin
                    idx_next   = '0;
                    state_next = tsdt_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            tsdt_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (s_tuser)
                        tsdt_pkg::REQ_CLEAR:
                        begin
                            idx_next   = '0;
                            state_next = tsdt_pkg::ST_CLEAR;
                        end
                        tsdt_pkg::REQ_WRITE:
                        begin
                            if (on_screen)
                            begin
                                draw_we    = 1'b1;
                                draw_waddr = write_addr[ADDR_W-1:0];
                                draw_wdata = {cell_attr, cell_char};
                            end
                        end
                        tsdt_pkg::REQ_COMMIT:
                        begin
                            idx_next   = '0;
                            count_next = '0;
                            state_next = tsdt_pkg::ST_COMMIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            tsdt_pkg::ST_CLEAR:
            begin
                draw_we = 1'b1;
                if (idx_reg == LAST_ADDR)
                begin
                    idx_next   = '0;
                    state_next = tsdt_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            tsdt_pkg::ST_COMMIT:
            begin
                cmp_valid_next = 1'b1;
                cmp_addr_next  = idx_reg;
                if (idx_reg == LAST_ADDR)
                begin
                    state_next = tsdt_pkg::ST_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            tsdt_pkg::ST_FLUSH:
            begin
                idx_next   = '0;
                state_next = tsdt_pkg::ST_DONE;
            end
            tsdt_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_cells_next  = count_wide[tsdt_pkg::CHANGED_W-1:0];
                    out_bytes_next  = part_wide[tsdt_pkg::BYTES_W-1:0];
                    out_choice_next = choice;
                    m_tvalid_next   = 1'b1;
                    state_next      = tsdt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsdt_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_bytes_reg, out_cells_reg};
    assign m_tuser  = out_choice_reg;

endmodule
`default_nettype wire
